// ----- rtl/core/gpm_pkg.sv -----
// Package for the gamepad to gameport mapper: item types, codes and byte decode.
`default_nettype none

package gpm_pkg;

  typedef struct packed {
    logic [7:0] raw_byte_0;
    logic [7:0] raw_byte_1;
    logic [7:0] raw_byte_2;
    logic [7:0] raw_byte_3;
    logic [7:0] raw_byte_4;
    logic [7:0] raw_byte_5;
    logic       read_ok;
  } in_item_t;

  typedef struct packed {
    logic [3:0] button_pins;
    logic [1:0] axis_x;
    logic [1:0] axis_y;
    logic [1:0] mode_used;
    logic       restart;
  } out_item_t;

  localparam int unsigned NUM_KEYS = 15;
  typedef logic [NUM_KEYS-1:0] keys_t;

  localparam int unsigned KEY_X      = 0;
  localparam int unsigned KEY_A      = 1;
  localparam int unsigned KEY_B      = 2;
  localparam int unsigned KEY_Y      = 3;
  localparam int unsigned KEY_START  = 4;
  localparam int unsigned KEY_SELECT = 5;
  localparam int unsigned KEY_HOME   = 6;
  localparam int unsigned KEY_RT     = 7;
  localparam int unsigned KEY_LT     = 8;
  localparam int unsigned KEY_RZ     = 9;
  localparam int unsigned KEY_LZ     = 10;
  localparam int unsigned KEY_UP     = 11;
  localparam int unsigned KEY_DOWN   = 12;
  localparam int unsigned KEY_LEFT   = 13;
  localparam int unsigned KEY_RIGHT  = 14;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_JUMP   = 2'd1;
  localparam logic [1:0] MODE_NES    = 2'd2;

  localparam logic [1:0] POS_MIN = 2'd0;
  localparam logic [1:0] POS_MID = 2'd1;
  localparam logic [1:0] POS_MAX = 2'd2;

  localparam logic [7:0] DEC_KEY   = 8'h17;
  localparam logic [7:0] ALL_ONES  = 8'hFF;

  // Undo the controller's byte scrambling; the add wraps at 8 bits.
  function automatic logic [7:0] decode_byte(input logic [7:0] b);
    decode_byte = (b ^ DEC_KEY) + DEC_KEY;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/gpm_if.sv -----
// Valid/ready channel interfaces for poll items and gameport result items.
`default_nettype none

interface gpm_in_if;
  logic               valid;
  logic               ready;
  gpm_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gpm_out_if;
  logic               valid;
  logic               ready;
  gpm_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/gamepad_to_gameport_mapper.sv -----
// Top level: decodes gamepad polls and maps buttons to gameport pins and axes.
//
// Channel  Dir  Handshake    Payload
// in_ch    in   valid/ready  six raw poll bytes, read_ok
// out_ch   out  valid/ready  button_pins, axis_x, axis_y, mode_used, restart
//
// Each item is decoded and mapped in the cycle it is accepted; its result appears
// in the output register on the next cycle, so one item per cycle is sustained while out_ch is ready.
// The input is ready whenever the output register is empty or being emptied.
// A stall on out_ch holds the result and blocks the input until it is taken.
// Synchronous active-low reset returns to normal mode with no buttons stored.
`default_nettype none

module gamepad_to_gameport_mapper (
  input  wire logic  clk,
  input  wire logic  rst_n,
  gpm_in_if.sink     in_ch,
  gpm_out_if.source  out_ch
);

  logic [1:0]           adapter_mode_r;
  logic [1:0]           adapter_mode_nxt;
  gpm_pkg::keys_t       pressed_r;
  gpm_pkg::keys_t       pressed_nxt;
  logic                 all_ones_r;
  logic                 all_ones_nxt;
  logic                 out_valid_r;
  gpm_pkg::out_item_t   out_item_r;
  gpm_pkg::out_item_t   out_item_nxt;

  logic                 accept;
  logic [7:0]           dec [6];
  logic [7:0]           n4;
  logic [7:0]           n5;
  logic                 all_dec;
  gpm_pkg::keys_t       fresh;
  gpm_pkg::keys_t       keys;
  logic                 all_now;
  logic                 jump;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

  always_comb begin
    dec[0] = gpm_pkg::decode_byte(in_ch.data.raw_byte_0);
    dec[1] = gpm_pkg::decode_byte(in_ch.data.raw_byte_1);
    dec[2] = gpm_pkg::decode_byte(in_ch.data.raw_byte_2);
    dec[3] = gpm_pkg::decode_byte(in_ch.data.raw_byte_3);
    dec[4] = gpm_pkg::decode_byte(in_ch.data.raw_byte_4);
    dec[5] = gpm_pkg::decode_byte(in_ch.data.raw_byte_5);
    all_dec = (dec[0] == gpm_pkg::ALL_ONES) && (dec[1] == gpm_pkg::ALL_ONES) &&
              (dec[2] == gpm_pkg::ALL_ONES) && (dec[3] == gpm_pkg::ALL_ONES) &&
              (dec[4] == gpm_pkg::ALL_ONES) && (dec[5] == gpm_pkg::ALL_ONES);

    // Button bits arrive active low.
    n4 = ~dec[4];
    n5 = ~dec[5];
    fresh = '0;
    fresh[gpm_pkg::KEY_X]      = n5[3];
    fresh[gpm_pkg::KEY_A]      = n5[4];
    fresh[gpm_pkg::KEY_B]      = n5[6];
    fresh[gpm_pkg::KEY_Y]      = n5[5];
    fresh[gpm_pkg::KEY_START]  = n4[2];
    fresh[gpm_pkg::KEY_SELECT] = n4[4];
    fresh[gpm_pkg::KEY_HOME]   = n4[3];
    fresh[gpm_pkg::KEY_RT]     = n4[1];
    fresh[gpm_pkg::KEY_LT]     = n4[5];
    fresh[gpm_pkg::KEY_RZ]     = n5[2];
    fresh[gpm_pkg::KEY_LZ]     = n5[7];
    fresh[gpm_pkg::KEY_UP]     = n5[0];
    fresh[gpm_pkg::KEY_DOWN]   = n4[6];
    fresh[gpm_pkg::KEY_LEFT]   = n5[1];
    fresh[gpm_pkg::KEY_RIGHT]  = n4[7];

    // A failed read falls back on the buttons stored by the last good one.
    keys    = in_ch.data.read_ok ? fresh : pressed_r;
    all_now = in_ch.data.read_ok ? all_dec : all_ones_r;

    jump = 1'b0;
    out_item_nxt = '0;
    case (adapter_mode_r)
      gpm_pkg::MODE_JUMP: begin
        out_item_nxt.button_pins = {2'b00, keys[gpm_pkg::KEY_A], keys[gpm_pkg::KEY_Y]};
        jump = keys[gpm_pkg::KEY_B];
      end
      gpm_pkg::MODE_NES: begin
        out_item_nxt.button_pins = {keys[gpm_pkg::KEY_SELECT], keys[gpm_pkg::KEY_START],
                                    keys[gpm_pkg::KEY_B], keys[gpm_pkg::KEY_A]};
      end
      default: begin
        out_item_nxt.button_pins = {keys[gpm_pkg::KEY_X], keys[gpm_pkg::KEY_A],
                                    keys[gpm_pkg::KEY_Y], keys[gpm_pkg::KEY_B]};
      end
    endcase

    if (keys[gpm_pkg::KEY_LEFT]) begin
      out_item_nxt.axis_x = gpm_pkg::POS_MIN;
    end else if (keys[gpm_pkg::KEY_RIGHT]) begin
      out_item_nxt.axis_x = gpm_pkg::POS_MAX;
    end else begin
      out_item_nxt.axis_x = gpm_pkg::POS_MID;
    end

    if (keys[gpm_pkg::KEY_UP] || jump) begin
      out_item_nxt.axis_y = gpm_pkg::POS_MIN;
    end else if (keys[gpm_pkg::KEY_DOWN]) begin
      out_item_nxt.axis_y = gpm_pkg::POS_MAX;
    end else begin
      out_item_nxt.axis_y = gpm_pkg::POS_MID;
    end

    out_item_nxt.mode_used = adapter_mode_r;
    out_item_nxt.restart   = all_now;

    // Mode hotkeys take effect from the next item; the first matching check wins.
    adapter_mode_nxt = adapter_mode_r;
    if (keys[gpm_pkg::KEY_SELECT]) begin
      if (keys[gpm_pkg::KEY_RIGHT]) begin
        adapter_mode_nxt = gpm_pkg::MODE_NES;
      end else if (keys[gpm_pkg::KEY_DOWN]) begin
        adapter_mode_nxt = gpm_pkg::MODE_NORMAL;
      end else if (keys[gpm_pkg::KEY_UP]) begin
        adapter_mode_nxt = gpm_pkg::MODE_JUMP;
      end
    end

    pressed_nxt  = all_now ? '0 : keys;
    all_ones_nxt = all_now;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adapter_mode_r <= gpm_pkg::MODE_NORMAL;
      pressed_r      <= '0;
      all_ones_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (accept) begin
        adapter_mode_r <= adapter_mode_nxt;
        pressed_r      <= pressed_nxt;
        all_ones_r     <= all_ones_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb_gamepad_to_gameport_mapper.sv -----
`timescale 1ns / 100ps
// Self-checking testbench: gamepad polls in, gameport pins, axes and mode checked per item.
module tb_gamepad_to_gameport_mapper;
  import gpm_pkg::*;

  localparam int RAND_PER_PHASE = 350;
  localparam int IDLE_LIMIT     = 2000;
  localparam int DRAIN_CYCLES   = 5;
  localparam int MAX_PRINTS     = 100;

  logic clk = 1'b0;
  logic rst_n;

  gpm_in_if  in_ch();
  gpm_out_if out_ch();

  gamepad_to_gameport_mapper dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Shadow copy of the mapper state.
  logic [1:0] mode_q;
  keys_t      held_keys;
  logic       last_all_ones;

  in_item_t  pending_polls[$];
  out_item_t expected_maps[$];

  int send_gap_pct;
  int recv_stall_pct;
  int error_count   = 0;
  int polls_sent    = 0;
  int stale_reads   = 0;
  int maps_checked  = 0;
  int restarts_seen = 0;
  int mode_hits[4]  = '{default: 0};
  int idle_cycles   = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_error(input string msg);
    if (error_count < MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [3:0] got,
                             input logic [3:0] want);
    if (got !== want)
      report_error($sformatf("result %0d: %s is %0h, expected %0h",
                             maps_checked, name, got, want));
  endtask

  // Inverse of the controller scrambling, so that chosen keys can be sent.
  function automatic logic [7:0] scramble(input logic [7:0] d);
    return (d - DEC_KEY) ^ DEC_KEY;
  endfunction

  function automatic in_item_t make_poll(input keys_t k, input logic ok);
    logic [7:0] n4;
    logic [7:0] n5;
    in_item_t   p;
    n5 = {k[KEY_LZ], k[KEY_B], k[KEY_Y], k[KEY_A], k[KEY_X], k[KEY_RZ],
          k[KEY_LEFT], k[KEY_UP]};
    n4 = {k[KEY_RIGHT], k[KEY_DOWN], k[KEY_LT], k[KEY_SELECT], k[KEY_HOME],
          k[KEY_START], k[KEY_RT], 1'($urandom_range(1))};
    p.raw_byte_0 = 8'($urandom);
    p.raw_byte_1 = 8'($urandom);
    p.raw_byte_2 = 8'($urandom);
    p.raw_byte_3 = 8'($urandom);
    p.raw_byte_4 = scramble(~n4);
    p.raw_byte_5 = scramble(~n5);
    p.read_ok    = ok;
    return p;
  endfunction

  function automatic in_item_t random_poll();
    int       pick;
    keys_t    k;
    in_item_t p;
    pick = $urandom_range(99);
    if (pick < 3) begin
      p = {48'hFFFF_FFFF_FFFF, 1'($urandom_range(1))};
    end else if (pick < 15) begin
      p = {$urandom, 17'($urandom)};
    end else begin
      k = keys_t'($urandom & $urandom);
      // Push Select plus directions often enough to walk through all modes.
      if ($urandom_range(99) < 25) begin
        k[KEY_SELECT] = 1'b1;
        k[KEY_UP]     = 1'($urandom_range(1));
        k[KEY_DOWN]   = 1'($urandom_range(1));
        k[KEY_RIGHT]  = 1'($urandom_range(1));
      end
      p = make_poll(k, $urandom_range(99) < 85);
    end
    return p;
  endfunction

  // Computes the gameport result for one poll and advances the shadow state.
  function automatic out_item_t map_poll(input in_item_t p);
    logic [7:0] d[6];
    logic [7:0] n4;
    logic [7:0] n5;
    logic       all_ff;
    logic       jump;
    out_item_t  r;
    if (p.read_ok) begin
      d[0] = (p.raw_byte_0 ^ DEC_KEY) + DEC_KEY;
      d[1] = (p.raw_byte_1 ^ DEC_KEY) + DEC_KEY;
      d[2] = (p.raw_byte_2 ^ DEC_KEY) + DEC_KEY;
      d[3] = (p.raw_byte_3 ^ DEC_KEY) + DEC_KEY;
      d[4] = (p.raw_byte_4 ^ DEC_KEY) + DEC_KEY;
      d[5] = (p.raw_byte_5 ^ DEC_KEY) + DEC_KEY;
      all_ff = 1'b1;
      for (int i = 0; i < 6; i++)
        if (d[i] != ALL_ONES) all_ff = 1'b0;
      n4 = ~d[4];
      n5 = ~d[5];
      held_keys[KEY_X]      = n5[3];
      held_keys[KEY_A]      = n5[4];
      held_keys[KEY_B]      = n5[6];
      held_keys[KEY_Y]      = n5[5];
      held_keys[KEY_START]  = n4[2];
      held_keys[KEY_SELECT] = n4[4];
      held_keys[KEY_HOME]   = n4[3];
      held_keys[KEY_RT]     = n4[1];
      held_keys[KEY_LT]     = n4[5];
      held_keys[KEY_RZ]     = n5[2];
      held_keys[KEY_LZ]     = n5[7];
      held_keys[KEY_UP]     = n5[0];
      held_keys[KEY_DOWN]   = n4[6];
      held_keys[KEY_LEFT]   = n5[1];
      held_keys[KEY_RIGHT]  = n4[7];
      last_all_ones = all_ff;
    end
    jump = 1'b0;
    case (mode_q)
      MODE_JUMP: begin
        r.button_pins = {2'b00, held_keys[KEY_A], held_keys[KEY_Y]};
        jump = held_keys[KEY_B];
      end
      MODE_NES: begin
        r.button_pins = {held_keys[KEY_SELECT], held_keys[KEY_START],
                         held_keys[KEY_B], held_keys[KEY_A]};
      end
      default: begin
        r.button_pins = {held_keys[KEY_X], held_keys[KEY_A],
                         held_keys[KEY_Y], held_keys[KEY_B]};
      end
    endcase
    r.axis_x = held_keys[KEY_LEFT] ? POS_MIN : held_keys[KEY_RIGHT] ? POS_MAX : POS_MID;
    r.axis_y = (held_keys[KEY_UP] || jump) ? POS_MIN :
               held_keys[KEY_DOWN] ? POS_MAX : POS_MID;
    r.mode_used = mode_q;
    r.restart   = last_all_ones;
    // The mode switch takes effect from the next poll; the last match wins.
    if (held_keys[KEY_SELECT]) begin
      if (held_keys[KEY_UP])    mode_q = MODE_JUMP;
      if (held_keys[KEY_DOWN])  mode_q = MODE_NORMAL;
      if (held_keys[KEY_RIGHT]) mode_q = MODE_NES;
    end
    if (last_all_ones) held_keys = '0;
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_polls.size() != 0 || in_ch.valid || expected_maps.size() != 0)
      @(posedge clk);
  endtask

  // Poll driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_maps.push_back(map_poll(in_ch.data));
        polls_sent++;
        if (!in_ch.data.read_ok) stale_reads++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_polls.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.data  <= pending_polls.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_maps.size() == 0) begin
          report_error("result arrived with no poll outstanding");
        end else begin
          want = expected_maps.pop_front();
          check_field("button_pins", out_ch.data.button_pins, want.button_pins);
          check_field("axis_x", 4'(out_ch.data.axis_x), 4'(want.axis_x));
          check_field("axis_y", 4'(out_ch.data.axis_y), 4'(want.axis_y));
          check_field("mode_used", 4'(out_ch.data.mode_used), 4'(want.mode_used));
          check_field("restart", 4'(out_ch.data.restart), 4'(want.restart));
          mode_hits[want.mode_used]++;
          if (want.restart) restarts_seen++;
          maps_checked++;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.data     = '0;
    out_ch.ready   = 1'b0;
    mode_q         = MODE_NORMAL;
    held_keys      = '0;
    last_all_ones  = 1'b0;
    send_gap_pct   = 16;
    recv_stall_pct = 48;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed polls: byte extremes, restart, failed reads and switches into each mode.
    pending_polls.push_back({48'h0, 1'b1});
    pending_polls.push_back({48'hFFFF_FFFF_FFFF, 1'b1});
    pending_polls.push_back({48'h0, 1'b0});
    pending_polls.push_back(make_poll(keys_t'('1), 1'b1));
    pending_polls.push_back({48'hFFFF_FFFF_FFFF, 1'b0});
    pending_polls.push_back(make_poll('0, 1'b1));
    pending_polls.push_back(make_poll(keys_t'((1 << KEY_A) | (1 << KEY_B) |
                            (1 << KEY_START) | (1 << KEY_SELECT)), 1'b1));
    pending_polls.push_back(make_poll(keys_t'((1 << KEY_SELECT) | (1 << KEY_DOWN)), 1'b1));
    pending_polls.push_back(make_poll(keys_t'((1 << KEY_B) | (1 << KEY_Y) |
                            (1 << KEY_A) | (1 << KEY_X) | (1 << KEY_LEFT)), 1'b1));
    pending_polls.push_back(make_poll(keys_t'((1 << KEY_SELECT) | (1 << KEY_UP)), 1'b1));
    pending_polls.push_back(make_poll(keys_t'(1 << KEY_B), 1'b1));
    pending_polls.push_back(make_poll(keys_t'((1 << KEY_Y) | (1 << KEY_A) |
                            (1 << KEY_X) | (1 << KEY_RIGHT)), 1'b1));
    pending_polls.push_back(make_poll(keys_t'((1 << KEY_B) | (1 << KEY_DOWN)), 1'b1));
    pending_polls.push_back(make_poll(keys_t'((1 << KEY_SELECT) | (1 << KEY_UP) |
                            (1 << KEY_DOWN)), 1'b1));
    pending_polls.push_back(make_poll(keys_t'((1 << KEY_SELECT) | (1 << KEY_UP) |
                            (1 << KEY_RIGHT)), 1'b1));
    pending_polls.push_back(make_poll(keys_t'((1 << KEY_SELECT) | (1 << KEY_DOWN) |
                            (1 << KEY_RIGHT)), 1'b1));
    pending_polls.push_back(make_poll(keys_t'((1 << KEY_SELECT) | (1 << KEY_DOWN)), 1'b1));
    pending_polls.push_back(make_poll(keys_t'((1 << KEY_DOWN) | (1 << KEY_RIGHT)), 1'b1));
    pending_polls.push_back(make_poll(keys_t'((1 << KEY_HOME) | (1 << KEY_RT) |
                            (1 << KEY_LT) | (1 << KEY_RZ) | (1 << KEY_LZ) |
                            (1 << KEY_UP) | (1 << KEY_DOWN)), 1'b1));
    pending_polls.push_back({$urandom, 16'($urandom), 1'b0});
    // Hold off the sender until every directed result is back.
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      send_gap_pct   = (phase == 0) ? 16 : (phase == 1) ? 48 : 0;
      recv_stall_pct = (phase == 0) ? 48 : (phase == 1) ? 16 : 0;
      for (int n = 0; n < RAND_PER_PHASE; n++)
        pending_polls.push_back(random_poll());
      wait_drained();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d polls (%0d with a failed read); checked %0d results.",
             polls_sent, stale_reads, maps_checked);
    $display("Modes seen: normal %0d, jump-run %0d, NES %0d; restart flagged %0d times.",
             mode_hits[MODE_NORMAL], mode_hits[MODE_JUMP], mode_hits[MODE_NES],
             restarts_seen);
    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ----- gamepad_to_gameport_mapper.f -----
rtl/core/gpm_pkg.sv
rtl/core/gpm_if.sv
rtl/core/gamepad_to_gameport_mapper.sv
tb/tb_gamepad_to_gameport_mapper.sv
